>>> hdl/gtlw_pkg.sv
// ----------------------------------------------------------------------------
// gtlw_pkg
// Shared types, constants and helper functions for the greedy line wrapper.
// ----------------------------------------------------------------------------
package gtlw_pkg;

  localparam int OFS_W      = 16;   // offset and length counter width
  localparam int OUT_W      = 16;   // width of offsets and lengths on the ports
  localparam int MAXW_W     = 12;   // max_line_width register width
  localparam int CP_W       = 21;   // decoded code point width
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // Output queue: two results per item at most
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 1'd1;

  // Wrap modes
  localparam logic MODE_WORD = 1'b0;
  localparam logic MODE_CHAR = 1'b1;

  localparam logic [MAXW_W-1:0] MAX_WIDTH_RST = 12'd50;

  typedef struct packed {
    logic             line_valid;
    logic [OFS_W-1:0] line_start;
    logic [OFS_W-1:0] line_end;
    logic [OFS_W-1:0] line_bytes;
    logic             cjk_seen;
    logic             last_line;
  } result_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic logic is_cjk(input logic [CP_W-1:0] cp);
    return ((cp >= 21'h04E00) && (cp <= 21'h09FFF)) ||
           ((cp >= 21'h03400) && (cp <= 21'h04DBF)) ||
           ((cp >= 21'h20000) && (cp <= 21'h2EBEF)) ||
           ((cp >= 21'h0F900) && (cp <= 21'h0FAFF)) ||
           ((cp >= 21'h2F800) && (cp <= 21'h2FA1F)) ||
           ((cp >= 21'h03040) && (cp <= 21'h0309F)) ||
           ((cp >= 21'h030A0) && (cp <= 21'h030FF)) ||
           ((cp >= 21'h0AC00) && (cp <= 21'h0D7AF));
  endfunction

  function automatic logic [OFS_W-1:0] sat_inc(input logic [OFS_W-1:0] x);
    return (x == {OFS_W{1'b1}}) ? x : x + OFS_W'(1);
  endfunction

endpackage

>>> hdl/greedy_text_line_wrapper.sv
// A finished line is queued when its item is taken and is offered on out_* once at the queue head.
// Throughput: one byte per cycle while in_stall is low; an item that ends a line and the text
// pushes two results, which drain one per cycle while out_stall is low from a four-entry output
// queue, and in_stall rises while fewer than two queue entries are free.
// Reset (rst_n low, synchronous): all text state cleared, queue emptied, wrap_mode = word,
// max_line_width = 50. End of text also clears the text state, cjk flag included.
// ----------------------------------------------------------------------------
// greedy_text_line_wrapper
// Greedy word/character line wrapper over a UTF-8 byte stream.
// ----------------------------------------------------------------------------
module greedy_text_line_wrapper (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [gtlw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gtlw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input bytes
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_text_byte,
  input  logic                             in_end_of_text,
  // finished lines
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_line_valid,
  output logic [gtlw_pkg::OUT_W-1:0]       out_line_start,
  output logic [gtlw_pkg::OUT_W-1:0]       out_line_end,
  output logic [gtlw_pkg::OUT_W-1:0]       out_line_bytes,
  output logic                             out_cjk_seen,
  output logic                             out_last_line
);
  import gtlw_pkg::*;

  // configuration
  logic              wrap_mode_r;
  logic [MAXW_W-1:0] max_width_r;

  // text state
  logic [OFS_W-1:0] byte_offset_r,    byte_offset_nxt;
  logic [OFS_W-1:0] cur_line_len_r,   cur_line_len_nxt;
  logic [OFS_W-1:0] cur_line_start_r, cur_line_start_nxt;
  logic [OFS_W-1:0] cur_line_end_r,   cur_line_end_nxt;
  logic [OFS_W-1:0] word_len_r,       word_len_nxt;
  logic [OFS_W-1:0] word_start_r,     word_start_nxt;
  logic             in_word_r,        in_word_nxt;
  logic [1:0]       char_left_r,      char_left_nxt;
  logic [2:0]       char_length_r,    char_length_nxt;
  logic [OFS_W-1:0] char_start_r,     char_start_nxt;
  logic [CP_W-1:0]  code_point_r,     code_point_nxt;
  logic             cjk_flag_r,       cjk_flag_nxt;

  // output queue
  result_t           q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] q_wr_r, q_wr_nxt;
  logic [QPTR_W-1:0] q_rd_r, q_rd_nxt;
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;

  logic in_acc, out_acc;
  logic [OFS_W-1:0] ofs, ofs1;
  logic eot;

  // word path
  logic             word_mode, sp, w_in, w_commit;
  logic [OFS_W-1:0] w_start, w_len_base, w_len, w_end;

  // character path
  logic             lead, c_done, c_commit, flag_new;
  logic [2:0]       dec_len, c_len, c_n;
  logic [CP_W-1:0]  dec_cp, c_cp;
  logic [1:0]       c_left;
  logic [OFS_W-1:0] c_start;

  // line assembly
  logic             p_go, p_sep, line_empty, p_fits, p_emit;
  logic [OFS_W-1:0] p_s, p_e, p_n;
  logic [OFS_W:0]   p_sum;
  logic [OFS_W-1:0] ln_start_a, ln_end_a, ln_len_a;
  result_t          res_line, res_eot;
  logic [1:0]       push_n;

  assign in_stall  = (q_cnt_r > QCNT_W'(QDEPTH - 2));
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = (q_cnt_r != '0);
  assign out_acc   = out_valid & ~out_stall;

  assign ofs  = byte_offset_r;
  assign ofs1 = byte_offset_r + OFS_W'(1);
  assign eot  = in_end_of_text;

  // ---- word machine ----
  assign word_mode  = (wrap_mode_r == MODE_WORD);
  assign sp         = is_space(in_text_byte);
  assign w_in       = in_word_r | ~sp;
  assign w_start    = in_word_r ? word_start_r : ofs;
  assign w_len_base = in_word_r ? word_len_r : '0;
  assign w_len      = sp ? w_len_base : sat_inc(w_len_base);
  assign w_commit   = word_mode & w_in & (sp | eot);
  assign w_end      = sp ? ofs : ofs1;

  // ---- UTF-8 character machine ----
  always_comb begin
    priority if (in_text_byte[7] == 1'b0) begin
      dec_len = 3'd1; dec_cp = CP_W'(in_text_byte);
    end else if ((in_text_byte & 8'hE0) == 8'hC0) begin
      dec_len = 3'd2; dec_cp = CP_W'(in_text_byte & 8'h1F);
    end else if ((in_text_byte & 8'hF0) == 8'hE0) begin
      dec_len = 3'd3; dec_cp = CP_W'(in_text_byte & 8'h0F);
    end else if ((in_text_byte & 8'hF8) == 8'hF0) begin
      dec_len = 3'd4; dec_cp = CP_W'(in_text_byte & 8'h07);
    end else begin
      // stray continuation or invalid lead: one-byte character
      dec_len = 3'd1; dec_cp = CP_W'(in_text_byte);
    end
  end

  assign lead     = (char_left_r == 2'd0);
  assign c_len    = lead ? dec_len : char_length_r;
  assign c_start  = lead ? ofs : char_start_r;
  assign c_cp     = lead ? dec_cp : {code_point_r[CP_W-7:0], in_text_byte[5:0]};
  assign c_left   = lead ? 2'(dec_len - 3'd1) : char_left_r - 2'd1;
  assign c_done   = (c_left == 2'd0);
  assign flag_new = cjk_flag_r | (c_done & is_cjk(c_cp));
  assign c_commit = ~word_mode & (c_done | eot);
  // truncated final character keeps only the bytes received
  assign c_n      = c_done ? c_len : c_len - {1'b0, c_left};

  // ---- line assembly: at most one piece per item ----
  assign p_go  = w_commit | c_commit;
  assign p_sep = w_commit;
  assign p_s   = w_commit ? w_start : c_start;
  assign p_e   = w_commit ? w_end : ofs1;
  assign p_n   = w_commit ? w_len : OFS_W'(c_n);
  assign p_sum = {1'b0, cur_line_len_r} + (OFS_W+1)'(p_sep) + {1'b0, p_n};

  assign line_empty = (cur_line_len_r == '0);
  assign p_fits     = (p_sum <= (OFS_W+1)'(max_width_r));
  assign p_emit     = p_go & ~line_empty & ~p_fits;

  always_comb begin
    ln_start_a = cur_line_start_r;
    ln_end_a   = cur_line_end_r;
    ln_len_a   = cur_line_len_r;
    if (p_go) begin
      if (line_empty || !p_fits) begin
        ln_start_a = p_s;
        ln_end_a   = p_e;
        ln_len_a   = p_n;
      end else begin
        ln_end_a = p_e;
        ln_len_a = p_sum[OFS_W-1:0];
      end
    end
  end

  always_comb begin
    res_line.line_valid = 1'b1;
    res_line.line_start = cur_line_start_r;
    res_line.line_end   = cur_line_end_r;
    res_line.line_bytes = cur_line_len_r;
    // the word break is seen before this byte is decoded
    res_line.cjk_seen   = w_commit ? cjk_flag_r : flag_new;
    res_line.last_line  = 1'b0;

    res_eot.line_valid  = (ln_len_a != '0);
    res_eot.line_start  = res_eot.line_valid ? ln_start_a : '0;
    res_eot.line_end    = res_eot.line_valid ? ln_end_a : '0;
    res_eot.line_bytes  = ln_len_a;
    res_eot.cjk_seen    = flag_new;
    res_eot.last_line   = 1'b1;
  end

  assign push_n = in_acc ? (2'(p_emit) + 2'(eot)) : 2'd0;

  // ---- next state ----
  always_comb begin
    byte_offset_nxt    = byte_offset_r;
    cur_line_len_nxt   = cur_line_len_r;
    cur_line_start_nxt = cur_line_start_r;
    cur_line_end_nxt   = cur_line_end_r;
    word_len_nxt       = word_len_r;
    word_start_nxt     = word_start_r;
    in_word_nxt        = in_word_r;
    char_left_nxt      = char_left_r;
    char_length_nxt    = char_length_r;
    char_start_nxt     = char_start_r;
    code_point_nxt     = code_point_r;
    cjk_flag_nxt       = cjk_flag_r;
    if (in_acc) begin
      if (eot) begin
        byte_offset_nxt    = '0;
        cur_line_len_nxt   = '0;
        cur_line_start_nxt = '0;
        cur_line_end_nxt   = '0;
        word_len_nxt       = '0;
        word_start_nxt     = '0;
        in_word_nxt        = 1'b0;
        char_left_nxt      = '0;
        char_length_nxt    = '0;
        char_start_nxt     = '0;
        code_point_nxt     = '0;
        cjk_flag_nxt       = 1'b0;
      end else begin
        byte_offset_nxt    = ofs1;
        cur_line_len_nxt   = ln_len_a;
        cur_line_start_nxt = ln_start_a;
        cur_line_end_nxt   = ln_end_a;
        if (word_mode) begin
          if (!in_word_r && !sp) begin
            word_start_nxt = ofs;
          end
          in_word_nxt  = w_in & ~w_commit;
          word_len_nxt = (w_in & ~w_commit) ? w_len : '0;
        end else begin
          in_word_nxt  = 1'b0;
          word_len_nxt = '0;
        end
        char_left_nxt   = c_left;
        char_length_nxt = c_len;
        char_start_nxt  = c_start;
        code_point_nxt  = c_cp;
        cjk_flag_nxt    = flag_new;
      end
    end
  end

  assign q_wr_nxt  = q_wr_r + QPTR_W'(push_n);
  assign q_rd_nxt  = q_rd_r + QPTR_W'(out_acc);
  assign q_cnt_nxt = q_cnt_r + QCNT_W'(push_n) - QCNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_mode_r      <= MODE_WORD;
      max_width_r      <= MAX_WIDTH_RST;
      byte_offset_r    <= '0;
      cur_line_len_r   <= '0;
      cur_line_start_r <= '0;
      cur_line_end_r   <= '0;
      word_len_r       <= '0;
      word_start_r     <= '0;
      in_word_r        <= 1'b0;
      char_left_r      <= '0;
      char_length_r    <= '0;
      char_start_r     <= '0;
      code_point_r     <= '0;
      cjk_flag_r       <= 1'b0;
      q_wr_r           <= '0;
      q_rd_r           <= '0;
      q_cnt_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WRAP_MODE: wrap_mode_r <= cfg_wdata[0];
          REG_MAX_WIDTH: max_width_r <= cfg_wdata[MAXW_W-1:0];
          default: ;
        endcase
      end
      byte_offset_r    <= byte_offset_nxt;
      cur_line_len_r   <= cur_line_len_nxt;
      cur_line_start_r <= cur_line_start_nxt;
      cur_line_end_r   <= cur_line_end_nxt;
      word_len_r       <= word_len_nxt;
      word_start_r     <= word_start_nxt;
      in_word_r        <= in_word_nxt;
      char_left_r      <= char_left_nxt;
      char_length_r    <= char_length_nxt;
      char_start_r     <= char_start_nxt;
      code_point_r     <= code_point_nxt;
      cjk_flag_r       <= cjk_flag_nxt;
      q_wr_r           <= q_wr_nxt;
      q_rd_r           <= q_rd_nxt;
      q_cnt_r          <= q_cnt_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (p_emit) begin
        q_mem_r[q_wr_r] <= res_line;
        if (eot) begin
          q_mem_r[q_wr_r + QPTR_W'(1)] <= res_eot;
        end
      end else if (eot) begin
        q_mem_r[q_wr_r] <= res_eot;
      end
    end
  end

  assign out_line_valid = q_mem_r[q_rd_r].line_valid;
  assign out_line_start = OUT_W'(q_mem_r[q_rd_r].line_start);
  assign out_line_end   = OUT_W'(q_mem_r[q_rd_r].line_end);
  assign out_line_bytes = OUT_W'(q_mem_r[q_rd_r].line_bytes);
  assign out_cjk_seen   = q_mem_r[q_rd_r].cjk_seen;
  assign out_last_line  = q_mem_r[q_rd_r].last_line;

  // ---- assertions ----
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QDEPTH))
    else $error("output queue count out of range");

  a_q_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (q_cnt_r <= QCNT_W'(QDEPTH - 2)))
    else $error("item taken without room for two results");

  a_eot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_text) |=> (byte_offset_r == '0 && cur_line_len_r == '0 &&
                                    !cjk_flag_r && char_left_r == 2'd0))
    else $error("text state not cleared after end of text");

  a_char_len: assert property (@(posedge clk) disable iff (!rst_n)
    (char_left_r != 2'd0) |-> (char_length_r > {1'b0, char_left_r}))
    else $error("pending character bytes exceed its length");

  a_char_mode_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && wrap_mode_r == MODE_CHAR) |=> !in_word_r)
    else $error("word in progress in character mode");

endmodule
